// ===== hdl/convolutional_encoder_kxn_top_assert.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the convolutional encoder
// Concurrent checks on clk_i with rst_ni as an asynchronous active-low reset.
// -----------------------------------------------------------------------------
`ifndef CONVOLUTIONAL_ENCODER_KXN_TOP_ASSERT_SVH
`define CONVOLUTIONAL_ENCODER_KXN_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define CEKXN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define CEKXN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`else

`define CEKXN_ASSERT(label, prop, msg)
`define CEKXN_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hdl/cekxn_pkg.sv =====
// -----------------------------------------------------------------------------
// Convolutional encoder package
// Register indexes and the control bundle shared by the top level and cells.
// -----------------------------------------------------------------------------
package cekxn_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  // Configuration register indexes; the fourth code selects nothing.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GENERATOR = 2'd0,
    CFG_FEEDBACK  = 2'd1,
    CFG_FB_ENABLE = 2'd2
  } cfg_index_e;

  // Control bundle fanned out to every cell of the row.
  typedef struct packed {
    logic advance;    // shift the tap register this cycle
    logic fb_enable;  // recursive mode
  } cekxn_ctrl_t;

endpackage

// ===== hdl/cekxn_cell.sv =====
// -----------------------------------------------------------------------------
// Convolutional encoder cell
// Shift register and parity taps of one input-output pair; folds its parity
// into the code bit passed along the row.
// -----------------------------------------------------------------------------
module cekxn_cell
  import cekxn_pkg::*;
#(
  parameter int unsigned MEMORY_LENGTH = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cekxn_ctrl_t            ctrl_i,
  input  logic                   data_bit_i,
  input  logic [MEMORY_LENGTH:0] gen_word_i,
  input  logic [MEMORY_LENGTH:0] fb_word_i,
  input  logic                   code_bit_i,
  output logic                   code_bit_o
);

  logic [MEMORY_LENGTH-1:0] taps_q;
  logic [MEMORY_LENGTH-1:0] taps_d;
  logic [MEMORY_LENGTH:0]   past_window;
  logic [MEMORY_LENGTH:0]   fb_masked;
  logic [MEMORY_LENGTH:0]   window;
  logic                     new_bit;

  // Past taps sit one place up; bit zero of the feedback word is dropped.
  assign past_window = {taps_q, 1'b0};
  assign fb_masked   = {fb_word_i[MEMORY_LENGTH:1], 1'b0};
  assign new_bit     = data_bit_i ^ (ctrl_i.fb_enable & (^(past_window & fb_masked)));
  assign window      = {taps_q, new_bit};

  assign code_bit_o = code_bit_i ^ (^(window & gen_word_i));

  always_comb begin
    taps_d = taps_q;
    if (ctrl_i.advance) begin
      taps_d = window[MEMORY_LENGTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= '0;
    end else begin
      taps_q <= taps_d;
    end
  end

endmodule

// ===== hdl/convolutional_encoder_kxn_top.sv =====
// -----------------------------------------------------------------------------
// Convolutional encoder, k inputs by n outputs
// Feedforward or recursive encoder built from a row of per-pair cells.
// -----------------------------------------------------------------------------
// Each request carries NUM_INPUTS information bits and yields exactly one group
// of NUM_OUTPUTS coded bits the cycle after it is taken. One request is taken
// every cycle unless stalled: all NUM_INPUTS x NUM_OUTPUTS cells shift in the
// same cycle and the coded bits land in a single output register, so the rate
// is set by that register alone. in_stall_o rises only while that register
// holds a result and out_stall_i is high. Each cell holds the MEMORY_LENGTH-bit
// shift register of one input-output pair; the code bit for output n is XOR-ed
// from cell to cell along the NUM_INPUTS cells of column n. The generator and
// feedback words are packed one (MEMORY_LENGTH+1)-bit word per pair, pair
// m*NUM_OUTPUTS+n lowest first, in registers capped at 64 bits; pair words
// that lie beyond bit 63 read as zero. A feedback word of 0 or 1 behaves as
// feedforward. Write configuration only while no request is in flight; writes
// to the unused index are dropped.
// -----------------------------------------------------------------------------
`include "convolutional_encoder_kxn_top_assert.svh"

module convolutional_encoder_kxn_top
  import cekxn_pkg::*;
#(
  parameter int unsigned NUM_INPUTS    = 1,
  parameter int unsigned NUM_OUTPUTS   = 2,
  parameter int unsigned MEMORY_LENGTH = 6,
  // Derived widths of the packed words and the configuration registers.
  localparam int unsigned PACK_W = NUM_INPUTS * NUM_OUTPUTS * (MEMORY_LENGTH + 1),
  localparam int unsigned REG_W  = (PACK_W > 64) ? 64 : PACK_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]       cfg_data_i,
  // input channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [NUM_INPUTS-1:0]  data_bits_i,
  // output channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [NUM_OUTPUTS-1:0] code_bits_o
);

  localparam int unsigned WORD_W = MEMORY_LENGTH + 1;

  // Configuration registers
  logic [REG_W-1:0] gen_q, gen_d;
  logic [REG_W-1:0] fb_q, fb_d;
  logic             fb_en_q, fb_en_d;

  // Handshake and output stage
  logic                   in_accept;
  logic                   out_valid_q, out_valid_d;
  logic [NUM_OUTPUTS-1:0] code_q, code_d;

  // Packed words widened to one full word per pair; missing bits read zero.
  logic [PACK_W-1:0] gen_ext;
  logic [PACK_W-1:0] fb_ext;

  cekxn_ctrl_t cell_ctrl;

  // Code bits travelling down each column of cells.
  logic [NUM_OUTPUTS-1:0] code_chain [NUM_INPUTS+1];

  // ---------------------------------------------------------------------------
  // Configuration: take a write at the given index, drop the unused index.
  // ---------------------------------------------------------------------------
  always_comb begin
    gen_d   = gen_q;
    fb_d    = fb_q;
    fb_en_d = fb_en_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GENERATOR: gen_d   = cfg_data_i;
        CFG_FEEDBACK:  fb_d    = cfg_data_i;
        CFG_FB_ENABLE: fb_en_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q   <= '0;
      fb_q    <= '0;
      fb_en_q <= 1'b0;
    end else begin
      gen_q   <= gen_d;
      fb_q    <= fb_d;
      fb_en_q <= fb_en_d;
    end
  end

  assign gen_ext = PACK_W'(gen_q);
  assign fb_ext  = PACK_W'(fb_q);

  // ---------------------------------------------------------------------------
  // Handshake: hold the request only while a finished result is refused.
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign cell_ctrl.advance   = in_accept;
  assign cell_ctrl.fb_enable = fb_en_q;

  // ---------------------------------------------------------------------------
  // Cell row: one cell per input-output pair, columns chained over inputs.
  // ---------------------------------------------------------------------------
  assign code_chain[0] = '0;

  for (genvar m = 0; m < NUM_INPUTS; m++) begin : g_input
    for (genvar n = 0; n < NUM_OUTPUTS; n++) begin : g_output
      localparam int unsigned PAIR = m * NUM_OUTPUTS + n;

      cekxn_cell #(
        .MEMORY_LENGTH(MEMORY_LENGTH)
      ) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .ctrl_i     (cell_ctrl),
        .data_bit_i (data_bits_i[m]),
        .gen_word_i (gen_ext[PAIR*WORD_W +: WORD_W]),
        .fb_word_i  (fb_ext[PAIR*WORD_W +: WORD_W]),
        .code_bit_i (code_chain[m][n]),
        .code_bit_o (code_chain[m+1][n])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on accept, drop once taken.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    code_d      = code_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
      code_d      = code_chain[NUM_INPUTS];
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign code_bits_o = code_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CEKXN_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_o,
                     "accepted request produced no result")
  `CEKXN_ASSERT_NEXT(a_no_invented_result,
                     out_valid_o && !out_stall_i && !in_accept, !out_valid_o,
                     "result repeated after being taken")
  `CEKXN_ASSERT_NEXT(a_code_only_on_accept, !in_accept && out_valid_o,
                     $stable(code_bits_o), "coded bits changed without a request")

endmodule
